FILE: hw/rtl/box_mipmap_chain_assert.svh
// Assertion macros shared by the mip chain RTL.
// Needs clk and arst_n in the scope of use.
`ifndef BOX_MIPMAP_CHAIN_ASSERT_SVH
`define BOX_MIPMAP_CHAIN_ASSERT_SVH

// same-cycle implication
`define MMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mip chain assertion failed");

// next-cycle implication
`define MMC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mip chain assertion failed");

`endif

FILE: hw/rtl/mmc_pkg.sv
// Shared types, constants and helpers of the mip chain.
// No dependencies.
`timescale 1ns / 1ps
package mmc_pkg;
	localparam int DIM_W   = 13;
	localparam int CH_W    = 8;
	localparam int NCH     = 4;
	localparam int HS_W    = 9;
	localparam int TOT_W   = 10;
	localparam int LEVEL_W = 4;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_LEVELS = 12;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(256);
	localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(256);
	localparam logic             RST_MODE   = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	localparam logic MODE_RGB = 1'b0;

	typedef logic [NCH-1:0][CH_W-1:0] pix_t;
	typedef logic [NCH-1:0][HS_W-1:0] psum_t;
	typedef logic [NCH-1:0][TOT_W-1:0] tot_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		pix_t               pix;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} dims_t;

	// floor(log2(v)), v >= 1
	function automatic logic [LEVEL_W-1:0] flog2(input logic [DIM_W-1:0] v);
		logic [LEVEL_W-1:0] r;
		r = '0;
		for (int i = 0; i < DIM_W; i++) begin
			if (v[i]) r = LEVEL_W'(i);
		end
		return r;
	endfunction
endpackage

FILE: hw/rtl/mmc_fifo.sv
// Small register queue, used between front and back and at the result side.
// No dependencies.
`timescale 1ns / 1ps
module mmc_fifo #(
	parameter int W     = 32,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_pop) rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end
endmodule

FILE: hw/rtl/mmc_back.sv
// Back end of the mip chain: walks the levels of one base pixel, one level per step.
// Depends on mmc_pkg and box_mipmap_chain_assert.svh.
`timescale 1ns / 1ps
`include "box_mipmap_chain_assert.svh"
module mmc_back
	import mmc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_LEVELS = DEF_MAX_LEVELS,
	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dims_t            dims,
	input  logic [LVL_W-1:0] levels,
	input  logic             clr,
	input  logic             in_empty,
	input  pix_t             in_data,
	output logic             in_pop,
	input  logic             out_full,
	output logic             out_push,
	output result_t          out_data
);
	localparam int OFF_W = DIM_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LVL  = 3'b010,
		ST_RD   = 3'b100
	} state_t;

	state_t           state_q, st_d;
	logic [LVL_W-1:0] s_q;
	logic [OFF_W-1:0] off_q;
	pix_t             px_q;
	psum_t            hs_q, rd_q;
	result_t          pend_q;
	logic             pend_v_q;

	logic [DIM_W-1:0] cx_q [MAX_LEVELS];
	logic [DIM_W-1:0] ry_q [MAX_LEVELS];
	pix_t             held_q [MAX_LEVELS];
	psum_t            rows_q [MAX_WIDTH];

	logic [DIM_W-1:0] sw, sh, dw, dh, sw_r, sh_r, dw_r, dh_r, cx, ry;
	logic [LVL_W:0]   s1;
	logic [DIM_W:0]   two_dw, two_dh;
	logic [OFF_W-1:0] idx;
	logic             idx_ok;
	pix_t             held_rd, newpx;
	psum_t            hs;
	tot_t             tot;
	logic             emit, finish, cnt_we, held_we, mem_we, mem_re, hs_we;

	assign s1     = {1'b0, s_q} + 1'b1;
	assign sw_r   = dims.w >> s_q;
	assign sh_r   = dims.h >> s_q;
	assign dw_r   = dims.w >> s1;
	assign dh_r   = dims.h >> s1;
	assign sw     = (sw_r == '0) ? DIM_W'(1) : sw_r;
	assign sh     = (sh_r == '0) ? DIM_W'(1) : sh_r;
	assign dw     = (dw_r == '0) ? DIM_W'(1) : dw_r;
	assign dh     = (dh_r == '0) ? DIM_W'(1) : dh_r;
	assign two_dw = {dw, 1'b0};
	assign two_dh = {dh, 1'b0};
	assign cx     = cx_q[s_q];
	assign ry     = ry_q[s_q];
	assign held_rd = held_q[s_q];
	assign idx    = off_q + OFF_W'(cx >> 1);
	assign idx_ok = (32'(idx) < MAX_WIDTH);

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			if (sw == DIM_W'(1)) hs[c] = {1'b0, px_q[c]} << 1;
			else hs[c] = HS_W'(held_rd[c]) + HS_W'(px_q[c]);
		end
	end

	always_comb begin
		st_d     = state_q;
		in_pop   = 1'b0;
		out_push = 1'b0;
		out_data = pend_q;
		emit     = 1'b0;
		finish   = 1'b0;
		cnt_we   = 1'b0;
		held_we  = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		hs_we    = 1'b0;
		tot      = '0;
		case (state_q)
			ST_IDLE: begin
				if (!in_empty) begin
					in_pop = 1'b1;
					st_d   = ST_LVL;
				end
			end
			ST_LVL: begin
				if (!out_full) begin
					if (s_q == levels) begin
						finish = 1'b1;
					end else begin
						cnt_we = 1'b1;
						if (sw != DIM_W'(1) && ({1'b0, cx} >= two_dw)) begin
							finish = 1'b1;
						end else if (sw != DIM_W'(1) && !cx[0]) begin
							held_we = 1'b1;
							finish  = 1'b1;
						end else if (sh == DIM_W'(1)) begin
							for (int c = 0; c < NCH; c++) tot[c] = {hs[c], 1'b0};
							emit = 1'b1;
						end else if ({1'b0, ry} >= two_dh) begin
							finish = 1'b1;
						end else if (!ry[0]) begin
							mem_we = idx_ok;
							finish = 1'b1;
						end else begin
							mem_re = 1'b1;
							hs_we  = 1'b1;
							st_d   = ST_RD;
						end
					end
				end
			end
			ST_RD: begin
				if (!out_full) begin
					for (int c = 0; c < NCH; c++) tot[c] = TOT_W'(rd_q[c]) + TOT_W'(hs_q[c]);
					emit = 1'b1;
					st_d = ST_LVL;
				end
			end
			default: st_d = ST_IDLE;
		endcase
		if (emit) begin
			out_push      = pend_v_q;
			out_data.last = 1'b0;
		end
		if (finish) begin
			out_push      = pend_v_q;
			out_data.last = 1'b1;
			st_d          = ST_IDLE;
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) newpx[c] = tot[c][TOT_W-1:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_v_q <= 1'b0;
			s_q      <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				cx_q[i] <= '0;
				ry_q[i] <= '0;
			end
		end else begin
			state_q <= st_d;
			if (in_pop) s_q <= '0;
			else if (emit) s_q <= s_q + 1'b1;
			if (emit) pend_v_q <= 1'b1;
			else if (finish) pend_v_q <= 1'b0;
			if (clr) begin
				for (int i = 0; i < MAX_LEVELS; i++) begin
					cx_q[i] <= '0;
					ry_q[i] <= '0;
				end
			end else if (cnt_we) begin
				if ({1'b0, cx} + 1'b1 >= {1'b0, sw}) begin
					cx_q[s_q] <= '0;
					ry_q[s_q] <= ({1'b0, ry} + 1'b1 >= {1'b0, sh}) ? '0 : ry + 1'b1;
				end else begin
					cx_q[s_q] <= cx + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			px_q  <= in_data;
			off_q <= '0;
		end else if (emit) begin
			px_q  <= newpx;
			off_q <= off_q + OFF_W'(dw);
		end
		if (emit) pend_q <= '{level: LEVEL_W'(s1), pix: newpx, last: 1'b0};
		if (hs_we) hs_q <= hs;
		if (held_we) held_q[s_q] <= px_q;
		if (mem_we) rows_q[idx[AW-1:0]] <= hs;
		if (mem_re) rd_q <= rows_q[idx[AW-1:0]];
	end

	`MMC_ASSERT_IMP(a_push_room, out_push, !out_full)
	`MMC_ASSERT_IMP(a_pop_idle, in_pop, (state_q == ST_IDLE) && !in_empty)
	`MMC_ASSERT_IMP(a_pend_busy, pend_v_q, state_q != ST_IDLE)
	`MMC_ASSERT_NXT(a_rd_to_lvl, (state_q == ST_RD) && !out_full, state_q == ST_LVL)
	`MMC_ASSERT_IMP(a_lvl_range, state_q == ST_LVL, s_q <= levels)
endmodule

FILE: hw/rtl/box_mipmap_chain.sv
// Streaming mip chain generator, 2x2 box filter: configuration registers,
// input and result queues. Depends on mmc_pkg, mmc_fifo and mmc_back.
`timescale 1ns / 1ps
// A base pixel waits in a four-entry input queue; the back end picks it up in
// its idle state, completes each level with a single source row in ST_LVL, reads
// the row buffer (one memory read port) in an extra ST_RD state for each level
// that needs it, and closes in ST_LVL; it takes no new pixel before it closes the
// last, and stalls while the result queue is full. Results leave through a four-entry
// queue; run_last marks the last result of one base pixel.
module box_mipmap_chain
	import mmc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [CH_W-1:0]    chan_0,
	input  logic [CH_W-1:0]    chan_1,
	input  logic [CH_W-1:0]    chan_2,
	input  logic [CH_W-1:0]    chan_3,
	output logic               empty,
	input  logic               pop,
	output logic [LEVEL_W-1:0] mip_level,
	output logic [CH_W-1:0]    out_0,
	output logic [CH_W-1:0]    out_1,
	output logic [CH_W-1:0]    out_2,
	output logic [CH_W-1:0]    out_3,
	output logic               run_last
);
	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	logic [DIM_W-1:0] width_q, height_q, wc, hc, dmax;
	logic             mode_q, wr, clr;
	logic [LEVEL_W-1:0] fl;
	logic [LVL_W-1:0] levels;
	dims_t            dims;
	pix_t             in_pix, q_pix;
	logic             q_empty, q_pop, r_full, r_push;
	result_t          r_in, r_out;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign clr    = wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT ||
		paddr[3:2] == REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			mode_q   <= RST_MODE;
		end else if (wr) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_MODE:   mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			REG_MODE:   prdata = DATA_W'(mode_q);
			default:    prdata = '0;
		endcase
	end

	assign wc = (width_q == '0) ? DIM_W'(1) :
		(32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
	assign hc = (height_q == '0) ? DIM_W'(1) :
		(32'(height_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : height_q;
	assign dmax = (wc > hc) ? wc : hc;
	assign fl   = flog2(dmax);
	assign levels = (fl == '0) ? '0 :
		(32'(fl) - 1 > MAX_LEVELS - 1) ? LVL_W'(MAX_LEVELS - 1) : LVL_W'(fl - 1'b1);
	assign dims = '{w: wc, h: hc};

	assign in_pix = {(mode_q == MODE_RGB) ? '0 : chan_3, chan_2, chan_1, chan_0};

	mmc_fifo #(.W($bits(pix_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(in_pix), .full(full),
		.pop(q_pop), .rdata(q_pix), .empty(q_empty)
	);

	mmc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_LEVELS(MAX_LEVELS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.dims(dims), .levels(levels), .clr(clr),
		.in_empty(q_empty), .in_data(q_pix), .in_pop(q_pop),
		.out_full(r_full), .out_push(r_push), .out_data(r_in)
	);

	mmc_fifo #(.W($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n),
		.push(r_push), .wdata(r_in), .full(r_full),
		.pop(pop), .rdata(r_out), .empty(empty)
	);

	assign mip_level = r_out.level;
	assign out_0     = r_out.pix[0];
	assign out_1     = r_out.pix[1];
	assign out_2     = r_out.pix[2];
	assign out_3     = r_out.pix[3];
	assign run_last  = r_out.last;
endmodule

FILE: dv/mmc_checker.sv
// Mip chain checker: snoops register writes, accepted pixels and accepted results,
// predicts every mip pixel and compares in order. Depends on mmc_pkg.
`timescale 1ns / 1ps
module mmc_checker
	import mmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	input  logic               push,
	input  logic               full,
	input  logic [CH_W-1:0]    chan_0,
	input  logic [CH_W-1:0]    chan_1,
	input  logic [CH_W-1:0]    chan_2,
	input  logic [CH_W-1:0]    chan_3,
	input  logic               empty,
	input  logic               pop,
	input  logic [LEVEL_W-1:0] mip_level,
	input  logic [CH_W-1:0]    out_0,
	input  logic [CH_W-1:0]    out_1,
	input  logic [CH_W-1:0]    out_2,
	input  logic [CH_W-1:0]    out_3,
	input  logic               run_last,
	output int                 errors,
	output int                 pending,
	output int                 mips_seen
);
	localparam int NLEV = DEF_MAX_LEVELS;
	localparam int ROWBUF = DEF_MAX_WIDTH;

	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic [CH_W-1:0]    ch[4];
		logic               last;
	} mip_pix_t;

	logic [DIM_W-1:0] img_w, img_h;
	logic             img_mode;
	int unsigned      col_pos[NLEV], row_pos[NLEV];
	logic [31:0]      left_pix[NLEV];
	logic [35:0]      pair_rows[ROWBUF];
	mip_pix_t         mip_q[$];

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > ROWBUF) return ROWBUF;
		return v;
	endfunction

	task automatic predict_mips(input logic [CH_W-1:0] c0, c1, c2, c3);
		int unsigned lw[NLEV], lh[NLEV];
		int unsigned nl, w, h, s, sw, sh, dw, dh, cx, ry, x, idx, off;
		int unsigned p[4], hs[4], tot[4];
		logic [35:0] v;
		bit have, done;
		int n;
		mip_pix_t e;
		nl = 0;
		off = 0;
		n = 0;
		w = clamp_dim(img_w);
		h = clamp_dim(img_h);
		do begin
			lw[nl] = w;
			lh[nl] = h;
			nl++;
			w = (w / 2 < 1) ? 1 : w / 2;
			h = (h / 2 < 1) ? 1 : h / 2;
		end while ((w != 1 || h != 1) && nl < NLEV);
		p[0] = c0; p[1] = c1; p[2] = c2; p[3] = c3;
		if (img_mode == MODE_RGB) p[3] = 0;
		for (s = 0; s < nl - 1; s++) begin
			sw = lw[s]; sh = lh[s]; dw = lw[s+1]; dh = lh[s+1];
			cx = col_pos[s]; ry = row_pos[s];
			have = 0;
			done = 0;
			x = 0;
			if (cx + 1 >= sw) begin
				col_pos[s] = 0;
				row_pos[s] = (ry + 1 >= sh) ? 0 : ry + 1;
			end else begin
				col_pos[s] = cx + 1;
			end
			if (sw == 1) begin
				for (int c = 0; c < 4; c++) hs[c] = 2 * p[c];
				have = 1;
			end else begin
				x = cx >> 1;
				if (cx < 2 * dw) begin
					if (cx[0] == 0) begin
						left_pix[s] = {p[3][7:0], p[2][7:0], p[1][7:0], p[0][7:0]};
					end else begin
						for (int c = 0; c < 4; c++) hs[c] = left_pix[s][8*c +: 8] + p[c];
						have = 1;
					end
				end
			end
			if (!have) break;
			if (sh == 1) begin
				for (int c = 0; c < 4; c++) tot[c] = 2 * hs[c];
				done = 1;
			end else if (ry < 2 * dh) begin
				idx = off + x;
				if (ry[0] == 0) begin
					if (idx < ROWBUF) begin
						for (int c = 0; c < 4; c++) v[9*c +: 9] = hs[c][8:0];
						pair_rows[idx] = v;
					end
				end else begin
					v = (idx < ROWBUF) ? pair_rows[idx] : '0;
					for (int c = 0; c < 4; c++) tot[c] = v[9*c +: 9] + hs[c];
					done = 1;
				end
			end
			if (!done) break;
			for (int c = 0; c < 4; c++) p[c] = (tot[c] >> 2) & 8'hff;
			if (img_mode == MODE_RGB) p[3] = 0;
			e.level = LEVEL_W'(s + 1);
			for (int c = 0; c < 4; c++) e.ch[c] = p[c][7:0];
			e.last = 0;
			mip_q.push_back(e);
			n++;
			off += dw;
		end
		if (n > 0) mip_q[mip_q.size()-1].last = 1;
	endtask

	task automatic check_mip();
		mip_pix_t e;
		logic [CH_W-1:0] got[4];
		got[0] = out_0; got[1] = out_1; got[2] = out_2; got[3] = out_3;
		if (mip_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result level %0d", $time, mip_level);
			return;
		end
		e = mip_q.pop_front();
		if (mip_level !== e.level) begin
			errors++;
			$display("%0t: mip_level exp %0d got %0d", $time, e.level, mip_level);
		end
		for (int c = 0; c < 4; c++)
			if (got[c] !== e.ch[c]) begin
				errors++;
				$display("%0t: out_%0d exp %0h got %0h", $time, c, e.ch[c], got[c]);
			end
		if (run_last !== e.last) begin
			errors++;
			$display("%0t: run_last exp %0b got %0b", $time, e.last, run_last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w = RST_WIDTH;
			img_h = RST_HEIGHT;
			img_mode = RST_MODE;
			for (int i = 0; i < NLEV; i++) begin
				col_pos[i] = 0;
				row_pos[i] = 0;
			end
			mip_q.delete();
			errors <= 0;
			pending <= 0;
			mips_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WIDTH: img_w = pwdata[DIM_W-1:0];
					REG_HEIGHT: img_h = pwdata[DIM_W-1:0];
					REG_MODE: img_mode = pwdata[0];
					default: ;
				endcase
				if (paddr[3:2] != 2'd3)
					for (int i = 0; i < NLEV; i++) begin
						col_pos[i] = 0;
						row_pos[i] = 0;
					end
			end
			if (!empty && pop) begin
				check_mip();
				mips_seen <= mips_seen + 1;
			end
			if (push && !full) predict_mips(chan_0, chan_1, chan_2, chan_3);
			pending <= mip_q.size();
		end
	end
endmodule

FILE: dv/tb_box_mipmap_chain.sv
// Testbench top for box_mipmap_chain: clock, reset, register setup, pixel frames
// and result draining; checking is in mmc_checker. Depends on mmc_pkg, box_mipmap_chain and mmc_checker.
`timescale 1ns / 1ps
module tb_box_mipmap_chain;
	import mmc_pkg::*;

	localparam int N_TARGET = 310;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic push, full, empty, pop, run_last;
	logic [CH_W-1:0] chan_0, chan_1, chan_2, chan_3, out_0, out_1, out_2, out_3;
	logic [LEVEL_W-1:0] mip_level;
	int errors, pending, mips_seen;
	int n_items, n_phases;
	bit no_idle;

	box_mipmap_chain dut (.*);
	mmc_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_box_mipmap_chain: errors");
		$finish;
	end

	always @(posedge clk or negedge arst_n)
		if (!arst_n) pop <= 0;
		else pop <= no_idle || ($urandom_range(99) >= 22);

	task automatic reg_write(input logic [1:0] idx, input int unsigned val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic settle();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// full only moves at a rising edge, so its value mid-cycle is what the next edge sees
	task automatic send_pixel(input logic [7:0] c0, c1, c2, c3);
		if (!no_idle && $urandom_range(99) < 22) begin
			push <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		push <= 1;
		chan_0 <= c0; chan_1 <= c1; chan_2 <= c2; chan_3 <= c3;
		do @(negedge clk); while (full);
		@(posedge clk);
		n_items++;
	endtask

	// kind: 0 random, 1 extremes
	task automatic run_frame(input int unsigned w, h, input logic mode, input int n, input int kind);
		logic [7:0] v;
		settle();
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_MODE, 32'(mode));
		n_phases++;
		for (int i = 0; i < n; i++) begin
			if (kind == 1) begin
				v = (i % 4 == 0) ? 8'h00 : (i % 4 == 1) ? 8'hff : (i % 4 == 2) ? 8'haa : 8'h55;
				send_pixel(v, ~v, v, 8'hff);
			end else begin
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end
		end
		push <= 0;
	endtask

	initial begin
		int unsigned w, h;
		int n;
		arst_n = 0;
		psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
		push <= 0; chan_0 <= '0; chan_1 <= '0; chan_2 <= '0; chan_3 <= '0;
		n_items = 0;
		n_phases = 0;
		no_idle = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		run_frame(4, 4, ~MODE_RGB, 16, 1);
		run_frame(3, 3, MODE_RGB, 9, 1);
		run_frame(0, 0, ~MODE_RGB, 2, 1);
		run_frame(1, 4, ~MODE_RGB, 4, 0);
		run_frame(8, 1, MODE_RGB, 8, 0);
		run_frame(8191, 2, ~MODE_RGB, 12, 0);
		run_frame(4096, 4096, MODE_RGB, 8, 0);
		run_frame(4096, 1, ~MODE_RGB, 64, 0);

		no_idle = 1;
		run_frame(8, 8, ~MODE_RGB, 64, 0);
		no_idle = 0;
		while (n_items < N_TARGET) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(4096, 1) : $urandom_range(20, 1);
			h = ($urandom_range(9) == 0) ? $urandom_range(4096, 1) : $urandom_range(20, 1);
			if (w * h <= 400)
				n = int'(w * h * $urandom_range(2, 1));
			else
				n = int'($urandom_range(60, 10));
			if (n > N_TARGET - n_items)
				n = N_TARGET - n_items;
			run_frame(w, h, 1'($urandom_range(1)), n, 0);
		end

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d pixels over %0d register setups, %0d mip pixels checked",
			n_items, n_phases, mips_seen);
		if (errors == 0)
			$display("tb_box_mipmap_chain: clean");
		else
			$display("tb_box_mipmap_chain: errors");
		$finish;
	end
endmodule
